// ===== hw/rtl/hex_grid_link_builder_unit_defines.svh =====
// assertion macros for the hex grid link builder
`ifndef HEX_GRID_LINK_BUILDER_UNIT_DEFINES_SVH
`define HEX_GRID_LINK_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define HGLB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HGLB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hglb_pkg.sv =====
// types, constants and neighbor geometry for the hex grid link builder
package hglb_pkg;

  localparam int unsigned MAX_COLS_DEF = 128;
  localparam int unsigned MAX_ROWS_DEF = 128;
  localparam int unsigned TERRAIN_W    = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 30;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] NUM_DIRS = 3'd6;

  typedef enum logic [2:0] {
    CFG_GRID_COLS,
    CFG_GRID_ROWS,
    CFG_TARGET_TYPE,
    CFG_BASE_WEIGHT,
    CFG_FULL_CELL,
    CFG_NULL_CELL,
    CFG_FROM_CELL,
    CFG_TO_CELL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic [6:0]         cell_col;
    logic [6:0]         cell_row;
    logic signed [15:0] terrain;
  } in_item_t;

  typedef struct packed {
    logic        has_link;
    logic [2:0]  direction;
    logic [6:0]  neighbor_col;
    logic [6:0]  neighbor_row;
    logic [13:0] neighbor_index;
    logic [13:0] source_index;
    logic [30:0] weight;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       inb;
    logic [7:0] col;
    logic [7:0] row;
  } nbr_t;

  // row in the high byte, column in the low byte
  function automatic logic is_cell(logic [15:0] pcell, logic [7:0] col, logic [7:0] row);
    return (pcell[15:8] == row) && (pcell[7:0] == col);
  endfunction

  // flat-top, odd columns shifted; direction 0 is up, then clockwise
  function automatic nbr_t nbr_geom(logic [6:0] col, logic [6:0] row, logic [2:0] dir,
                                    logic [7:0] cols, logic [7:0] rows);
    nbr_t               n;
    logic signed [1:0]  dc;
    logic signed [1:0]  dr;
    logic signed [9:0]  nc;
    logic signed [9:0]  nr;
    logic               valid_dir;
    valid_dir = 1'b1;
    dc = 2'sd0;
    dr = 2'sd0;
    case (dir)
      3'd0: begin
        dc = 2'sd0;  dr = 2'sd1;
      end
      3'd1: begin
        dc = 2'sd1;  dr = col[0] ? 2'sd1 : 2'sd0;
      end
      3'd2: begin
        dc = 2'sd1;  dr = col[0] ? 2'sd0 : -2'sd1;
      end
      3'd3: begin
        dc = 2'sd0;  dr = -2'sd1;
      end
      3'd4: begin
        dc = -2'sd1; dr = col[0] ? 2'sd0 : -2'sd1;
      end
      3'd5: begin
        dc = -2'sd1; dr = col[0] ? 2'sd1 : 2'sd0;
      end
      default: valid_dir = 1'b0;
    endcase
    nc = $signed({3'b000, col}) + 10'(dc);
    nr = $signed({3'b000, row}) + 10'(dr);
    n.inb = valid_dir && (nc >= 10'sd0) && (nr >= 10'sd0) &&
            (nc < $signed({2'b00, cols})) && (nr < $signed({2'b00, rows}));
    n.col = nc[7:0];
    n.row = nr[7:0];
    return n;
  endfunction

endpackage

// ===== hw/rtl/hex_grid_link_builder_unit.sv =====
// hex grid link builder: terrain ram plus per-query neighbor scan and link output
// a write transaction is taken while idle; a query stalls the input until the last of its
// n = 1..6 results is loaded, so a new query waits for the previous one; the first result
// is registered after the neighbor scan, and output stalls hold the emit phase longer
// each query reads the single-port terrain ram in turn: once for the cell, once per neighbor
// reset restores the register defaults and clears control state; the ram is not cleared
`include "hex_grid_link_builder_unit_defines.svh"

module hex_grid_link_builder_unit #(
  parameter int unsigned MAX_COLS = hglb_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = hglb_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hglb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hglb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hglb_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hglb_pkg::out_item_t             out_item_o
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [7:0]  MAXC8 = 8'(MAX_COLS);
  localparam logic [7:0]  MAXR8 = 8'(MAX_ROWS);

  function automatic logic [AW-1:0] cell_addr(logic [7:0] col, logic [7:0] row);
    return AW'(row) * AW'(MAX_COLS) + AW'(col);
  endfunction

  // configuration registers
  logic [7:0]         cols_cfg_q, rows_cfg_q;
  logic signed [15:0] target_q;
  logic [29:0]        base_q;
  logic [15:0]        full_q, null_q, from_q, to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= 8'd128;
      rows_cfg_q <= 8'd128;
      target_q   <= '0;
      base_q     <= '0;
      full_q     <= 16'hFFFF;
      null_q     <= 16'hFFFF;
      from_q     <= 16'hFFFF;
      to_q       <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (hglb_pkg::cfg_reg_e'(cfg_idx_i))
        hglb_pkg::CFG_GRID_COLS:   cols_cfg_q <= cfg_data_i[7:0];
        hglb_pkg::CFG_GRID_ROWS:   rows_cfg_q <= cfg_data_i[7:0];
        hglb_pkg::CFG_TARGET_TYPE: target_q   <= $signed(cfg_data_i[15:0]);
        hglb_pkg::CFG_BASE_WEIGHT: base_q     <= cfg_data_i[29:0];
        hglb_pkg::CFG_FULL_CELL:   full_q     <= cfg_data_i[15:0];
        hglb_pkg::CFG_NULL_CELL:   null_q     <= cfg_data_i[15:0];
        hglb_pkg::CFG_FROM_CELL:   from_q     <= cfg_data_i[15:0];
        hglb_pkg::CFG_TO_CELL:     to_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // grid size in use, zero counts as one, capped at the array size
  logic [7:0] cols, rows;

  always_comb begin
    cols = cols_cfg_q;
    rows = rows_cfg_q;
    if (cols_cfg_q == 8'd0) cols = 8'd1;
    else if (cols_cfg_q > MAXC8) cols = MAXC8;
    if (rows_cfg_q == 8'd0) rows = 8'd1;
    else if (rows_cfg_q > MAXR8) rows = MAXR8;
  end

  // query state
  hglb_pkg::state_e    state_q, state_d;
  logic [6:0]          col_q, row_q;
  logic                at_from_q, at_to_q, self_full_q;
  logic [13:0]         src_q;
  logic [2:0]          k_q;
  logic                ctr_ok_q;
  logic                p_ok_q;
  logic [2:0]          p_dir_q;
  logic [5:0]          mask_q;
  logic                out_valid_q;
  hglb_pkg::out_item_t out_q, out_d;

  logic                in_acc;
  logic                is_query;
  logic [7:0]          in_col8, in_row8;
  logic                in_range;
  logic                ctr_in_ok;
  logic [15:0]         src_full;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [15:0]         ram_rdata;
  logic                rd_match;

  hglb_pkg::nbr_t      scan_nbr, emit_nbr;
  logic                scan_ok;
  logic [2:0]          sel_dir;
  logic [5:0]          rest_mask;
  logic                emit_empty;
  logic                nbr_full;
  logic [15:0]         emit_idx;
  logic                out_load;

  assign in_stall_o = (state_q != hglb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_query   = (in_item_i.cmd == hglb_pkg::CMD_QUERY);
  assign in_col8    = {1'b0, in_item_i.cell_col};
  assign in_row8    = {1'b0, in_item_i.cell_row};
  assign in_range   = (in_col8 < MAXC8) && (in_row8 < MAXR8);
  assign ctr_in_ok  = (in_col8 < cols) && (in_row8 < rows) &&
                      !hglb_pkg::is_cell(null_q, in_col8, in_row8);
  assign src_full   = 16'(in_item_i.cell_row) * 16'(cols) + 16'(in_item_i.cell_col);

  assign rd_match = ($signed(ram_rdata) == target_q);

  // neighbor whose read is issued this cycle
  assign scan_nbr = hglb_pkg::nbr_geom(col_q, row_q, k_q, cols, rows);
  assign scan_ok  = scan_nbr.inb &&
                    !hglb_pkg::is_cell(null_q, scan_nbr.col, scan_nbr.row) &&
                    !(at_to_q && hglb_pkg::is_cell(from_q, scan_nbr.col, scan_nbr.row)) &&
                    !(!at_to_q && at_from_q &&
                      hglb_pkg::is_cell(to_q, scan_nbr.col, scan_nbr.row));

  // lowest pending direction goes out next
  always_comb begin
    sel_dir = 3'd0;
    for (int d = 5; d >= 0; d--) begin
      if (mask_q[d]) sel_dir = 3'(d);
    end
  end

  assign rest_mask  = mask_q & ~(6'b000001 << sel_dir);
  assign emit_empty = !ctr_ok_q || (mask_q == 6'd0);
  assign emit_nbr   = hglb_pkg::nbr_geom(col_q, row_q, sel_dir, cols, rows);
  assign nbr_full   = hglb_pkg::is_cell(full_q, emit_nbr.col, emit_nbr.row);
  assign emit_idx   = 16'(emit_nbr.row) * 16'(cols) + 16'(emit_nbr.col);

  always_comb begin
    out_d = '0;
    out_d.source_index = src_q;
    if (emit_empty) begin
      out_d.last = 1'b1;
    end else begin
      out_d.has_link       = 1'b1;
      out_d.direction      = sel_dir;
      out_d.neighbor_col   = emit_nbr.col[6:0];
      out_d.neighbor_row   = emit_nbr.row[6:0];
      out_d.neighbor_index = emit_idx[13:0];
      out_d.weight         = (self_full_q || nbr_full) ? {base_q, 1'b0} : {1'b0, base_q};
      out_d.last           = (rest_mask == 6'd0);
    end
  end

  // next state and ram port control
  always_comb begin
    state_d  = state_q;
    ram_we   = 1'b0;
    ram_addr = '0;
    out_load = 1'b0;
    unique case (state_q)
      hglb_pkg::ST_IDLE: begin
        if (in_range) ram_addr = cell_addr(in_col8, in_row8);
        ram_we = in_acc && (in_item_i.cmd == hglb_pkg::CMD_WRITE) && in_range;
        if (in_acc && is_query) state_d = hglb_pkg::ST_SCAN;
      end
      hglb_pkg::ST_SCAN: begin
        if (scan_nbr.inb) ram_addr = cell_addr(scan_nbr.col, scan_nbr.row);
        if (k_q == hglb_pkg::NUM_DIRS) state_d = hglb_pkg::ST_EMIT;
      end
      hglb_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (emit_empty || (rest_mask == 6'd0)) state_d = hglb_pkg::ST_IDLE;
        end
      end
      default: state_d = hglb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hglb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      ctr_ok_q    <= 1'b0;
      p_ok_q      <= 1'b0;
      p_dir_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && is_query) begin
        k_q      <= '0;
        ctr_ok_q <= ctr_in_ok;
        mask_q   <= '0;
      end
      if (state_q == hglb_pkg::ST_SCAN) begin
        k_q     <= k_q + 3'd1;
        p_ok_q  <= scan_ok;
        p_dir_q <= k_q;
        // read data belongs to the access issued in the previous cycle
        if (k_q == 3'd0) begin
          ctr_ok_q <= ctr_ok_q && rd_match;
        end else begin
          mask_q[p_dir_q] <= p_ok_q && rd_match;
        end
      end
      if (out_load) begin
        mask_q      <= rest_mask;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      col_q       <= in_item_i.cell_col;
      row_q       <= in_item_i.cell_row;
      at_from_q   <= hglb_pkg::is_cell(from_q, in_col8, in_row8);
      at_to_q     <= hglb_pkg::is_cell(to_q, in_col8, in_row8);
      self_full_q <= hglb_pkg::is_cell(full_q, in_col8, in_row8);
      src_q       <= src_full[13:0];
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  hglb_ram #(
    .WIDTH(hglb_pkg::TERRAIN_W),
    .DEPTH(DEPTH)
  ) u_terrain_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_item_i.terrain),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `HGLB_ASSERT_IMP(a_write_only_idle, ram_we, state_q == hglb_pkg::ST_IDLE, "ram write outside idle")
  `HGLB_ASSERT_IMP(a_link_unless_last, out_valid_o && !out_item_o.last, out_item_o.has_link, "empty transaction not marked last")
  `HGLB_ASSERT_NXT(a_scan_steps, state_q == hglb_pkg::ST_SCAN && k_q != hglb_pkg::NUM_DIRS, state_q == hglb_pkg::ST_SCAN && k_q == $past(k_q) + 3'd1, "neighbor scan skipped a step")

endmodule

// ===== hw/rtl/hglb_ram.sv =====
// generic single-port ram with registered read
module hglb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/tb_hex_grid_link_builder_unit.sv =====
`timescale 1ns / 1ps
// testbench for hex_grid_link_builder_unit: terrain writes and link queries against a predictor
module tb_hex_grid_link_builder_unit;
  import hglb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SPAN        = MAX_COLS_DEF;
  localparam int DRAIN_TAIL  = 16;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [7:0]         cols;
    logic [7:0]         rows;
    logic signed [15:0] target;
    logic [29:0]        weight;
    logic [15:0]        full_cell;
    logic [15:0]        null_cell;
    logic [15:0]        from_cell;
    logic [15:0]        to_cell;
  } grid_setup_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_RUNS,
    STALL_HEAVY
  } stall_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;

  hex_grid_link_builder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // predictor state
  grid_setup_t        cur;
  logic signed [15:0] terrain_mem [0:SPAN*SPAN-1];
  out_item_t          pending_links [$];
  out_item_t          want_link;

  // stimulus side: which cells hold a written value
  bit                 cell_written [0:SPAN*SPAN-1];
  int                 burst_left = 0;
  int                 err_count = 0;

  stall_mode_e        stall_mode = STALL_NONE;
  int                 stall_left = 0;
  int                 stall_run = 0;
  bit                 stall_level = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int used_dim(logic [7:0] v, int unsigned limit);
    if (v == 8'd0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [15:0] pack_cell(int col, int row);
    return {8'(row), 8'(col)};
  endfunction

  function automatic bit cell_match(logic [15:0] p, int col, int row);
    return (int'(p[15:8]) == row) && (int'(p[7:0]) == col);
  endfunction

  // odd columns sit half a cell higher
  function automatic void neighbor_of(int k, int col, int row, output int nc, output int nr);
    bit odd;
    odd = (col % 2) == 1;
    case (k)
      0: begin
        nc = col;     nr = row + 1;
      end
      1: begin
        nc = col + 1; nr = odd ? row + 1 : row;
      end
      2: begin
        nc = col + 1; nr = odd ? row : row - 1;
      end
      3: begin
        nc = col;     nr = row - 1;
      end
      4: begin
        nc = col - 1; nr = odd ? row : row - 1;
      end
      default: begin
        nc = col - 1; nr = odd ? row + 1 : row;
      end
    endcase
  endfunction

  function automatic void find_links(int col, int row);
    out_item_t   links [$];
    out_item_t   r;
    int          cols, rows, nc, nr, k;
    bit          at_from, at_to, self_full;
    logic [13:0] src;
    logic [30:0] w;
    cols = used_dim(cur.cols, MAX_COLS_DEF);
    rows = used_dim(cur.rows, MAX_ROWS_DEF);
    src = 14'(row * cols + col);
    if (col < cols && row < rows && !cell_match(cur.null_cell, col, row) &&
        terrain_mem[row * SPAN + col] == cur.target) begin
      at_from = cell_match(cur.from_cell, col, row);
      at_to = cell_match(cur.to_cell, col, row);
      self_full = cell_match(cur.full_cell, col, row);
      for (k = 0; k < 6; k++) begin
        neighbor_of(k, col, row, nc, nr);
        if (nc < 0 || nc >= cols || nr < 0 || nr >= rows) continue;
        if (cell_match(cur.null_cell, nc, nr)) continue;
        // the blocked pair is checked from whichever end we stand on
        if (at_to) begin
          if (cell_match(cur.from_cell, nc, nr)) continue;
        end else if (at_from && cell_match(cur.to_cell, nc, nr)) begin
          continue;
        end
        if (terrain_mem[nr * SPAN + nc] != cur.target) continue;
        w = {1'b0, cur.weight};
        if (self_full || cell_match(cur.full_cell, nc, nr)) w = w << 1;
        r = '0;
        r.has_link = 1'b1;
        r.direction = 3'(k);
        r.neighbor_col = 7'(nc);
        r.neighbor_row = 7'(nr);
        r.neighbor_index = 14'(nr * cols + nc);
        r.source_index = src;
        r.weight = w;
        links.push_back(r);
      end
    end
    if (links.size() == 0) begin
      r = '0;
      r.source_index = src;
      links.push_back(r);
    end
    r = links.pop_back();
    r.last = 1'b1;
    links.push_back(r);
    foreach (links[i]) pending_links.push_back(links[i]);
  endfunction

  // predict at each accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (in_item_i.cmd == CMD_WRITE)
        terrain_mem[int'(in_item_i.cell_row) * SPAN + int'(in_item_i.cell_col)] = in_item_i.terrain;
      else
        find_links(in_item_i.cell_col, in_item_i.cell_row);
    end
  end

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_links.size() == 0) begin
        flag_error($sformatf("result %h with nothing expected", out_item_o));
      end else begin
        want_link = pending_links.pop_front();
        check_field("has_link", out_item_o.has_link, want_link.has_link);
        check_field("direction", out_item_o.direction, want_link.direction);
        check_field("neighbor_col", out_item_o.neighbor_col, want_link.neighbor_col);
        check_field("neighbor_row", out_item_o.neighbor_row, want_link.neighbor_row);
        check_field("neighbor_index", out_item_o.neighbor_index, want_link.neighbor_index);
        check_field("source_index", out_item_o.source_index, want_link.source_index);
        check_field("weight", out_item_o.weight, want_link.weight);
        check_field("last", out_item_o.last, want_link.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_SPARSE: out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_RUNS: begin
          if (stall_run == 0) begin
            stall_level = ~stall_level;
            stall_run = $urandom_range(1, 8);
          end
          stall_run--;
          out_stall_i <= stall_level;
        end
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    flag_error("cycle limit reached");
    $display("CHECK FAILED");
    $finish;
  end

  // returns at the edge where the transaction is taken; valid stays up for the next one
  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0)
        gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 4);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_links.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic load_config(grid_setup_t s);
    int         i;
    logic [29:0] data;
    wait_drain();
    for (i = 0; i < 8; i++) begin
      case (cfg_reg_e'(i))
        CFG_GRID_COLS:   data = 30'(s.cols);
        CFG_GRID_ROWS:   data = 30'(s.rows);
        CFG_TARGET_TYPE: data = {14'd0, s.target};
        CFG_BASE_WEIGHT: data = s.weight;
        CFG_FULL_CELL:   data = 30'(s.full_cell);
        CFG_NULL_CELL:   data = 30'(s.null_cell);
        CFG_FROM_CELL:   data = 30'(s.from_cell);
        default:         data = 30'(s.to_cell);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_data_i <= data;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur = s;
  endtask

  function automatic grid_setup_t setup_of(int cols, int rows, logic signed [15:0] tt,
                                           logic [29:0] w, logic [15:0] fc, logic [15:0] nc,
                                           logic [15:0] fr, logic [15:0] tc);
    grid_setup_t s;
    s.cols = 8'(cols);
    s.rows = 8'(rows);
    s.target = tt;
    s.weight = w;
    s.full_cell = fc;
    s.null_cell = nc;
    s.from_cell = fr;
    s.to_cell = tc;
    return s;
  endfunction

  // a query may only touch cells that already hold a value
  function automatic bit query_safe(int col, int row);
    int k, nc, nr;
    if (!cell_written[row * SPAN + col]) return 1'b0;
    for (k = 0; k < 6; k++) begin
      neighbor_of(k, col, row, nc, nr);
      if (nc >= 0 && nc < SPAN && nr >= 0 && nr < SPAN && !cell_written[nr * SPAN + nc])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic put_terrain(int col, int row, logic signed [15:0] t);
    in_item_t it;
    it.cmd = CMD_WRITE;
    it.cell_col = 7'(col);
    it.cell_row = 7'(row);
    it.terrain = t;
    cell_written[row * SPAN + col] = 1'b1;
    send_item(it);
  endtask

  task automatic ask_links(int col, int row);
    in_item_t it;
    it.cmd = CMD_QUERY;
    it.cell_col = 7'(col);
    it.cell_row = 7'(row);
    it.terrain = 16'($urandom);
    if (query_safe(col, row)) send_item(it);
  endtask

  task automatic fill_patch(int c0, int c1, int r0, int r1, int pct);
    int                 c, r;
    logic signed [15:0] t;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        t = ($urandom_range(0, 99) < pct) ? cur.target : 16'($urandom);
        put_terrain(c, r, t);
      end
    end
  endtask

  task automatic ask_some(int c0, int c1, int r0, int r1, int count);
    repeat (count) ask_links($urandom_range(c0, c1), $urandom_range(r0, r1));
  endtask

  task automatic test_reset_values();
    // registers as reset leaves them: full grid, target zero, weight zero
    fill_patch(0, 2, 0, 2, 100);
    ask_links(0, 0);
    ask_links(1, 1);
    wait_drain();
  endtask

  task automatic test_special_cells();
    // from/to pair on the upper-right link of column 1, row 1; full cell next door
    load_config(setup_of(5, 4, 16'sd7, 30'd1000, pack_cell(2, 1), pack_cell(3, 2),
                         pack_cell(1, 1), pack_cell(2, 2)));
    fill_patch(0, 6, 0, 5, 100);
    put_terrain(3, 1, 16'sh7FFF);
    put_terrain(0, 3, -16'sd32768);
    put_terrain(4, 0, -16'sd1);
    ask_links(1, 1);
    ask_links(2, 2);
    ask_links(2, 1);
    ask_links(3, 2);
    ask_links(3, 1);
    ask_links(0, 0);
    ask_links(4, 3);
    ask_links(4, 0);
    ask_links(5, 1);
    ask_links(1, 4);
    ask_links(2, 3);
    ask_links(3, 3);
    // same cell at both ends blocks nothing; null cell outside the grid; max weight doubled
    load_config(setup_of(5, 4, 16'sd7, 30'h3FFF_FFFF, pack_cell(1, 1), pack_cell(9, 1),
                         pack_cell(2, 1), pack_cell(2, 1)));
    ask_links(1, 1);
    ask_links(2, 1);
    ask_links(2, 2);
    wait_drain();
  endtask

  task automatic test_grid_limits();
    // zero rows and columns count as one
    load_config(setup_of(0, 0, 16'sh7FFF, 30'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    fill_patch(0, 2, 0, 2, 100);
    ask_links(0, 0);
    ask_links(1, 0);
    ask_links(0, 1);
    // oversize column count saturates: one long row
    load_config(setup_of(255, 1, -16'sd32768, 30'd77, pack_cell(127, 0), 16'hFFFF,
                         16'hFFFF, 16'hFFFF));
    fill_patch(124, 127, 0, 2, 80);
    fill_patch(0, 2, 0, 2, 80);
    ask_links(127, 0);
    ask_links(126, 0);
    ask_links(125, 0);
    ask_links(127, 1);
    ask_links(0, 0);
    ask_links(1, 0);
    // full size grid, top corner carries the full cell and a blocked link
    load_config(setup_of(128, 200, 16'($urandom), 30'h3FFF_FFFF, pack_cell(127, 127),
                         pack_cell(64, 64), pack_cell(127, 127), pack_cell(126, 127)));
    fill_patch(125, 127, 125, 127, 85);
    fill_patch(62, 66, 63, 65, 85);
    ask_links(127, 127);
    ask_links(126, 127);
    ask_links(126, 126);
    ask_links(64, 64);
    ask_links(63, 64);
    ask_links(65, 64);
    ask_some(125, 127, 125, 127, 3);
    ask_some(62, 66, 63, 65, 3);
    wait_drain();
  endtask

  function automatic grid_setup_t rand_setup();
    grid_setup_t s;
    int          c, r, k, nc, nr, sel;
    s.cols = 8'($urandom_range(2, 6));
    s.rows = 8'($urandom_range(2, 6));
    s.target = 16'($urandom);
    sel = $urandom_range(0, 9);
    s.weight = (sel == 0) ? 30'd0 : (sel == 1) ? 30'h3FFF_FFFF : 30'($urandom);
    s.full_cell = ($urandom_range(0, 9) < 6) ?
                  pack_cell($urandom_range(0, s.cols - 1), $urandom_range(0, s.rows - 1)) :
                  16'hFFFF;
    s.null_cell = ($urandom_range(0, 1) == 0) ?
                  pack_cell($urandom_range(0, s.cols - 1), $urandom_range(0, s.rows - 1)) :
                  16'hFFFF;
    c = $urandom_range(0, s.cols - 1);
    r = $urandom_range(0, s.rows - 1);
    k = $urandom_range(0, 5);
    neighbor_of(k, c, r, nc, nr);
    sel = $urandom_range(0, 19);
    if (sel < 14) begin
      s.from_cell = pack_cell(c, r);
      s.to_cell = pack_cell(nc, nr);
    end else if (sel < 17) begin
      s.from_cell = pack_cell(c, r);
      s.to_cell = pack_cell(c, r);
    end else begin
      s.from_cell = 16'hFFFF;
      s.to_cell = 16'hFFFF;
    end
    return s;
  endfunction

  task automatic test_random_traffic();
    int                 phase, n, sel, cols, rows, cmax, rmax;
    logic signed [15:0] t;
    for (phase = 0; phase < 2; phase++) begin
      load_config(rand_setup());
      cols = used_dim(cur.cols, MAX_COLS_DEF);
      rows = used_dim(cur.rows, MAX_ROWS_DEF);
      cmax = (cols + 1 > SPAN - 1) ? SPAN - 1 : cols + 1;
      rmax = (rows + 1 > SPAN - 1) ? SPAN - 1 : rows + 1;
      fill_patch(0, cmax, 0, rmax, 75);
      for (n = 0; n < 20; n++) begin
        // hold off once until every link already asked for is back
        if (phase == 1 && n == 10) wait_drain();
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          ask_links($urandom_range(0, cols), $urandom_range(0, rows));
        end else if (sel < 90) begin
          t = ($urandom_range(0, 3) != 0) ? cur.target : 16'($urandom);
          put_terrain($urandom_range(0, cmax), $urandom_range(0, rmax), t);
        end else begin
          put_terrain($urandom_range(0, SPAN - 1), $urandom_range(0, SPAN - 1), 16'($urandom));
        end
      end
    end
    wait_drain();
  endtask

  initial begin
    cur = setup_of(128, 128, 16'sd0, 30'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_special_cells();
    test_grid_limits();
    test_random_traffic();
    wait_drain();
    while (pending_links.size() != 0) begin
      want_link = pending_links.pop_front();
      flag_error($sformatf("link %h never came out", want_link));
    end
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
